/* rtl/core/cau_pkg.sv */
// Shared types, constants and the saturation helper for the complex arithmetic unit.
// Depends on nothing; every other file of the unit imports it.
package cau_pkg;

    localparam int DW = 32;          // operand and result width
    localparam int FB = 16;          // fraction bits
    localparam int PW = 2 * DW;      // exact product width
    localparam int SW = PW + 1;      // width of a sum of two products
    localparam int NW = PW + FB;     // numerator magnitude after the fraction shift
    localparam int RW = PW + 1;      // divider remainder width

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_real;
        logic signed [31:0] res_imag;
        logic [1:0]         status;
    } rsp_t;

    typedef struct packed {
        op_t                op;
        logic signed [SW-1:0] sum_re;
        logic signed [SW-1:0] sum_im;
        logic [PW-1:0]        den;
    } front_t;

    typedef struct packed {
        logic signed [DW-1:0] val;
        logic                 sat;
    } clamp_t;

    typedef struct packed {
        op_t           op;
        logic          dz;
        logic          neg_re;
        logic          neg_im;
        logic          ovf_re;
        logic          ovf_im;
        logic [DW-1:0] q_re;
        logic [DW-1:0] q_im;
        clamp_t        fix_re;
        clamp_t        fix_im;
    } div_t;

    function automatic clamp_t clamp(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] maxv;
        logic signed [SW-1:0] minv;
        clamp_t c;
        maxv = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
        minv = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
        if (x > maxv)
        begin
            c.val = maxv[DW-1:0];
            c.sat = 1'b1;
        end
        else if (x < minv)
        begin
            c.val = minv[DW-1:0];
            c.sat = 1'b1;
        end
        else
        begin
            c.val = x[DW-1:0];
            c.sat = 1'b0;
        end
        return c;
    endfunction

endpackage

/* rtl/core/complex_arithmetic_unit.sv */
// Complex add, subtract, multiply and divide on signed Q16.16 parts, fully pipelined: one
// transaction is taken every clock unless the result side stalls, and it passes three front-end
// stages for products and sums, one divider set-up stage, 32 restoring divider stages and one
// output register. The 32-stage divider sets the latency; a stall on the result side holds
// the whole pipeline. A zero divisor returns zero with status 1; any clamped part gives status 2.
module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic   en;
    logic   f_valid, d_valid;
    front_t f_data;
    div_t   d_data;
    logic   rsp_valid_reg;
    rsp_t   rsp_reg, rsp_next;
    clamp_t c_re, c_im;

    assign en        = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !en;

    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req_valid),
        .in_data   (req),
        .out_valid (f_valid),
        .out_data  (f_data)
    );

    cau_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_data   (f_data),
        .out_valid (d_valid),
        .out_data  (d_data)
    );

    function automatic clamp_t quot_part(input logic neg, input logic ovf,
                                         input logic [DW-1:0] q);
        clamp_t c;
        if (ovf)
        begin
            c.val = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            c.sat = 1'b1;
        end
        else if (neg)
        begin
            c.sat = q > {1'b1, {(DW-1){1'b0}}};
            c.val = c.sat ? {1'b1, {(DW-1){1'b0}}} : -q;
        end
        else
        begin
            c.sat = q[DW-1];
            c.val = c.sat ? {1'b0, {(DW-1){1'b1}}} : q;
        end
        return c;
    endfunction

    always_comb
    begin
        if (d_data.op == OP_DIV)
        begin
            c_re = quot_part(d_data.neg_re, d_data.ovf_re, d_data.q_re);
            c_im = quot_part(d_data.neg_im, d_data.ovf_im, d_data.q_im);
        end
        else
        begin
            c_re = d_data.fix_re;
            c_im = d_data.fix_im;
        end
        if (d_data.op == OP_DIV && d_data.dz)
        begin
            rsp_next.res_real = '0;
            rsp_next.res_imag = '0;
            rsp_next.status   = ST_DIVZERO;
        end
        else
        begin
            rsp_next.res_real = c_re.val;
            rsp_next.res_imag = c_im.val;
            rsp_next.status   = (c_re.sat || c_im.sat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    a_divzero_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_DIVZERO |-> rsp.res_real == 0 && rsp.res_imag == 0)
        else $error("divide by zero result is not zero");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_DIVZERO || rsp.status == ST_SAT)
        else $error("undefined status code");

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_SAT |->
            rsp.res_real == 32'sh7fffffff || rsp.res_real == 32'sh80000000 ||
            rsp.res_imag == 32'sh7fffffff || rsp.res_imag == 32'sh80000000)
        else $error("saturation reported without a clamped part");
`endif

endmodule

/* rtl/core/cau_front.sv */
// Front end of the unit: operand register, six exact products, then the sums.
// Depends on cau_pkg.
module cau_front
    import cau_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  req_t   in_data,
    output logic   out_valid,
    output front_t out_data
);

    logic                 v1_reg, v2_reg, v3_reg;
    req_t                 s1_reg;
    op_t                  op2_reg;
    logic signed [PW-1:0] prr_reg, pii_reg, pri_reg, pir_reg, pbr_reg, pbi_reg;
    logic signed [PW-1:0] prr_next, pii_next, pri_next, pir_next, pbr_next, pbi_next;
    logic signed [DW:0]   add_re_reg, add_im_reg, add_re_next, add_im_next;
    front_t               f3_reg, f3_next;

    always_comb
    begin
        prr_next = PW'(s1_reg.a_real) * PW'(s1_reg.b_real);
        pii_next = PW'(s1_reg.a_imag) * PW'(s1_reg.b_imag);
        pri_next = PW'(s1_reg.a_real) * PW'(s1_reg.b_imag);
        pir_next = PW'(s1_reg.a_imag) * PW'(s1_reg.b_real);
        pbr_next = PW'(s1_reg.b_real) * PW'(s1_reg.b_real);
        pbi_next = PW'(s1_reg.b_imag) * PW'(s1_reg.b_imag);
        if (s1_reg.op == OP_SUB)
        begin
            add_re_next = (DW+1)'(s1_reg.a_real) - (DW+1)'(s1_reg.b_real);
            add_im_next = (DW+1)'(s1_reg.a_imag) - (DW+1)'(s1_reg.b_imag);
        end
        else
        begin
            add_re_next = (DW+1)'(s1_reg.a_real) + (DW+1)'(s1_reg.b_real);
            add_im_next = (DW+1)'(s1_reg.a_imag) + (DW+1)'(s1_reg.b_imag);
        end
    end

    always_comb
    begin
        f3_next.op  = op2_reg;
        f3_next.den = $unsigned(pbr_reg) + $unsigned(pbi_reg);
        unique case (op2_reg)
            OP_MUL:
            begin
                f3_next.sum_re = SW'(prr_reg) - SW'(pii_reg);
                f3_next.sum_im = SW'(pri_reg) + SW'(pir_reg);
            end
            OP_DIV:
            begin
                f3_next.sum_re = SW'(prr_reg) + SW'(pii_reg);
                f3_next.sum_im = SW'(pir_reg) - SW'(pri_reg);
            end
            default:
            begin
                f3_next.sum_re = SW'(add_re_reg);
                f3_next.sum_im = SW'(add_im_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg     <= in_data;
            op2_reg    <= s1_reg.op;
            prr_reg    <= prr_next;
            pii_reg    <= pii_next;
            pri_reg    <= pri_next;
            pir_reg    <= pir_next;
            pbr_reg    <= pbr_next;
            pbi_reg    <= pbi_next;
            add_re_reg <= add_re_next;
            add_im_reg <= add_im_next;
            f3_reg     <= f3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = f3_reg;

endmodule

/* rtl/core/cau_div.sv */
// Divider pipeline: sign and overflow set-up, then one restoring quotient bit per stage.
// Depends on cau_pkg; results of the other operations are clamped at set-up, then ride along.
module cau_div
    import cau_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  front_t in_data,
    output logic   out_valid,
    output div_t   out_data
);

    typedef struct packed {
        div_t          body;
        logic [RW-1:0] rem_re;
        logic [RW-1:0] rem_im;
        logic [PW-1:0] den;
    } dstage_t;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [DW-1:0] q;
    } step_t;

    function automatic step_t div_step(input logic [RW-1:0] rem, input logic [DW-1:0] q,
                                       input logic [PW-1:0] den);
        logic [RW-1:0] remx;
        step_t s;
        remx = {rem[RW-2:0], q[DW-1]};
        if (remx >= RW'(den))
        begin
            s.rem = remx - RW'(den);
            s.q   = {q[DW-2:0], 1'b1};
        end
        else
        begin
            s.rem = remx;
            s.q   = {q[DW-2:0], 1'b0};
        end
        return s;
    endfunction

    logic          v_reg [0:DW];
    dstage_t       st_reg [0:DW];
    dstage_t       st_next [0:DW];
    logic [PW-1:0] mag_re, mag_im;
    logic [NW-1:0] sh_re, sh_im;

    // Set-up stage: magnitudes, the fraction shift, the early overflow test, and the clamp of the other results.
    // A quotient of 2^DW or more is bound to saturate, so only DW bits are developed.
    always_comb
    begin
        mag_re = in_data.sum_re[SW-1] ? PW'(-in_data.sum_re) : PW'(in_data.sum_re);
        mag_im = in_data.sum_im[SW-1] ? PW'(-in_data.sum_im) : PW'(in_data.sum_im);
        sh_re  = NW'(mag_re) << FB;
        sh_im  = NW'(mag_im) << FB;
        st_next[0].den         = in_data.den;
        st_next[0].rem_re      = RW'(sh_re[NW-1:DW]);
        st_next[0].rem_im      = RW'(sh_im[NW-1:DW]);
        st_next[0].body.op     = in_data.op;
        st_next[0].body.dz     = (in_data.den == '0);
        st_next[0].body.neg_re = in_data.sum_re[SW-1];
        st_next[0].body.neg_im = in_data.sum_im[SW-1];
        st_next[0].body.ovf_re = RW'(sh_re[NW-1:DW]) >= RW'(in_data.den);
        st_next[0].body.ovf_im = RW'(sh_im[NW-1:DW]) >= RW'(in_data.den);
        st_next[0].body.q_re   = sh_re[DW-1:0];
        st_next[0].body.q_im   = sh_im[DW-1:0];
        if (in_data.op == OP_MUL)
        begin
            st_next[0].body.fix_re = clamp(in_data.sum_re >>> FB);
            st_next[0].body.fix_im = clamp(in_data.sum_im >>> FB);
        end
        else
        begin
            st_next[0].body.fix_re = clamp(in_data.sum_re);
            st_next[0].body.fix_im = clamp(in_data.sum_im);
        end
    end

    genvar k;
    generate
        for (k = 1; k <= DW; k++)
        begin : g_step
            step_t s_re, s_im;
            always_comb
            begin
                s_re = div_step(st_reg[k-1].rem_re, st_reg[k-1].body.q_re, st_reg[k-1].den);
                s_im = div_step(st_reg[k-1].rem_im, st_reg[k-1].body.q_im, st_reg[k-1].den);
                st_next[k]           = st_reg[k-1];
                st_next[k].rem_re    = s_re.rem;
                st_next[k].rem_im    = s_im.rem;
                st_next[k].body.q_re = s_re.q;
                st_next[k].body.q_im = s_im.q;
            end
        end
    endgenerate

    generate
        for (k = 0; k <= DW; k++)
        begin : g_reg
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k] <= st_next[k];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[DW];
    assign out_data  = st_reg[DW].body;

endmodule

/* bench/cau_checker.sv */
// Checker for the complex arithmetic unit: watches both channels, predicts each result
// and compares it field by field. Depends on cau_pkg for the transaction types.
`timescale 1ns / 1ps
module cau_checker
    import cau_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    input  logic    req_stall,
    input  req_t    req,
    input  logic    rsp_valid,
    input  logic    rsp_stall,
    input  rsp_t    rsp,
    output int      fail_count,
    output int      pending
);

    rsp_t expected_q[$];

    function automatic logic signed [31:0] clip(input logic signed [127:0] x,
                                                 inout logic sat);
        if (x > 128'sh7fffffff)
        begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (x < -128'sh80000000)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    // Signed division truncating toward zero, done on magnitudes.
    function automatic logic signed [127:0] div_trunc(input logic signed [127:0] n,
                                                       input logic signed [127:0] d);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (n < 0) ? -n : n;
        q = mag / d;
        return (n < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic rsp_t compute_result(input req_t t);
        logic signed [127:0] ar, ai, br, bi, re, im, den;
        logic sat;
        rsp_t r;
        ar = t.a_real;
        ai = t.a_imag;
        br = t.b_real;
        bi = t.b_imag;
        sat = 1'b0;
        case (t.op)
            OP_ADD:
            begin
                re = ar + br;
                im = ai + bi;
            end
            OP_SUB:
            begin
                re = ar - br;
                im = ai - bi;
            end
            OP_MUL:
            begin
                re = (ar * br - ai * bi) >>> FB;
                im = (ar * bi + ai * br) >>> FB;
            end
            default:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                begin
                    r.res_real = '0;
                    r.res_imag = '0;
                    r.status = ST_DIVZERO;
                    return r;
                end
                re = div_trunc((ar * br + ai * bi) <<< FB, den);
                im = div_trunc((ai * br - ar * bi) <<< FB, den);
            end
        endcase
        r.res_real = clip(re, sat);
        r.res_imag = clip(im, sat);
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_q.insert(expected_q.size(), compute_result(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected transaction: res_real %h res_imag %h status %0d",
                           rsp.res_real, rsp.res_imag, rsp.status);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.res_real !== want.res_real)
                        $error("res_real: expected %h, got %h", want.res_real, rsp.res_real);
                    if (rsp.res_imag !== want.res_imag)
                        $error("res_imag: expected %h, got %h", want.res_imag, rsp.res_imag);
                    if (rsp.status !== want.status)
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                    if (rsp !== want)
                        fail_count <= fail_count + 1;
                end
            end
        end
    end

endmodule

/* bench/tb_top.sv */
// Top of the complex arithmetic unit bench: clock, reset, stimulus and verdict.
// Depends on cau_pkg, complex_arithmetic_unit and cau_checker.
`timescale 1ns / 1ps
module tb_top;
    import cau_pkg::*;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    int   fail_count;
    int   pending;
    int   cycles;
    bit   sending_done;
    bit   long_hold;

    complex_arithmetic_unit dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    cau_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] pick_part();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(0, 2) - 1;
            4, 5: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            6: return $signed($urandom_range(0, 32'hfffff)) - 32'sh80000;
            default: return $urandom;
        endcase
    endfunction

    // Send one transaction after a random gap (none when nogap is set), holding it until it is taken.
    task automatic send(input op_t op, input logic [31:0] ar, input logic [31:0] ai,
                        input logic [31:0] br, input logic [31:0] bi, input bit nogap);
        int gap;
        gap = nogap ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= '{op: op, a_real: ar, a_imag: ai, b_real: br, b_imag: bi};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Receiver: a random stall per transaction, plus one long hold-off early on.
    initial
    begin
        int wait_n;
        rsp_stall <= 1'b1;
        long_hold = 1'b1;
        @(posedge rst_n);
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
        forever
        begin
            wait_n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 1))
                wait_n = 0;
            repeat (wait_n)
            begin
                rsp_stall <= 1'b1;
                @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("complex_arithmetic_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] ext[6];
        int i;
        ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h00010000, 32'hffff0000};
        cycles = 0;
        sending_done = 1'b0;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: extremes on every operation, zero divisor, saturation.
        for (i = 0; i < 4; i++)
        begin
            send(op_t'(i), ext[0], ext[1], ext[0], ext[1], 1);
            send(op_t'(i), ext[1], ext[1], ext[1], ext[0], 1);
            send(op_t'(i), ext[4], ext[5], ext[3], ext[4], 1);
        end
        send(OP_DIV, ext[4], ext[5], 32'h0, 32'h0, 1);
        send(OP_DIV, ext[0], ext[1], 32'h0, 32'h0, 1);
        send(OP_DIV, ext[0], ext[0], 32'h1, 32'h0, 1);
        send(OP_DIV, ext[1], ext[3], 32'h0, 32'h1, 1);
        send(OP_MUL, ext[3], ext[3], ext[3], ext[2], 1);
        send(OP_MUL, 32'hffffffff, 32'h1, 32'h1, 32'h1, 1);
        send(OP_ADD, ext[2], ext[2], ext[2], ext[2], 1);
        send(OP_SUB, ext[2], ext[1], ext[2], ext[0], 1);
        // Back-to-back while the receiver is held off, to fill the pipeline.
        while (long_hold)
            send(op_t'($urandom_range(0, 3)), pick_part(), pick_part(),
                 pick_part(), pick_part(), 1);
        for (i = 0; i < 500; i++)
            send(op_t'($urandom_range(0, 3)), pick_part(), pick_part(),
                 pick_part(), pick_part(), 0);
        req_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("complex_arithmetic_unit: match");
        else
            $display("complex_arithmetic_unit: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_div.sv
rtl/core/complex_arithmetic_unit.sv
bench/cau_checker.sv
bench/tb_top.sv
